// ===== hdl/vn_pkg.sv =====
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;

    // Depth of the queue between front and back.
    localparam int unsigned VN_QDEPTH = 4;
    localparam int unsigned VN_QPTR_W = $clog2(VN_QDEPTH);

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/vn_front.sv =====
// Front end: accepts a vector, forms magnitudes, signs and the sum of squares.
`timescale 1ns / 1ps
module vn_front import vn_pkg::*; #(
    parameter int COMP_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_x,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_y,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_z,
    input  t_q_stat                       i_q_stat,
    output logic                          o_q_wr,
    output logic [3+5*COMP_WIDTH-1:0]     o_q_data
);
    localparam int CW = COMP_WIDTH;
    localparam int SW = 2 * COMP_WIDTH;

    logic                  r_fv;
    logic [2:0]            r_neg;
    logic [2:0][CW-1:0]    r_mag;
    logic                  w_acc;
    logic [2:0][CW-1:0]    w_raw;
    logic [SW-1:0]         w_sum;

    assign w_raw   = {i_comp_z, i_comp_y, i_comp_x};
    assign o_stall = r_fv & i_q_stat.full;
    assign w_acc   = i_valid & ~o_stall;
    assign o_q_wr  = r_fv & ~i_q_stat.full;

    // Valid flag of the front register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_acc) begin
            r_fv <= 1'b1;
        end else if (o_q_wr) begin
            r_fv <= 1'b0;
        end
    end

    // Sign and magnitude per component; the most negative value maps to 2^(CW-1)
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int l = 0; l < 3; l++) begin
                r_neg[l] <= w_raw[l][CW-1];
                r_mag[l] <= w_raw[l][CW-1] ? (~w_raw[l] + CW'(1)) : w_raw[l];
            end
        end
    end

    // Sum of squares, cannot exceed 3 * 2^(2CW-2)
    always_comb begin
        w_sum = '0;
        for (int l = 0; l < 3; l++) begin
            w_sum = w_sum + SW'(r_mag[l] * r_mag[l]);
        end
    end

    assign o_q_data = {r_neg, r_mag, w_sum};

endmodule

// ===== hdl/vn_queue.sv =====
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module vn_queue import vn_pkg::*; #(
    parameter int DATA_W = 83
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_rd,
    output logic [DATA_W-1:0] o_rdata,
    output t_q_stat           o_stat
);
    logic [DATA_W-1:0]    r_mem [0:VN_QDEPTH-1];
    logic [VN_QPTR_W-1:0] r_wp;
    logic [VN_QPTR_W-1:0] r_rp;
    logic [VN_QPTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (VN_QPTR_W+1)'(VN_QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rdata      = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + VN_QPTR_W'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + VN_QPTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + (VN_QPTR_W+1)'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - (VN_QPTR_W+1)'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== hdl/vn_back.sv =====
// Back end: pipelined square root, pipelined three-lane divide, saturation.
`timescale 1ns / 1ps
module vn_back import vn_pkg::*; #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_q_stat                       i_q_stat,
    input  logic [3+5*COMP_WIDTH-1:0]     i_q_data,
    output logic                          o_q_rd,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [FRAC_BITS:0]     o_unit_x,
    output logic signed [FRAC_BITS:0]     o_unit_y,
    output logic signed [FRAC_BITS:0]     o_unit_z,
    output logic                          o_zero_length
);
    localparam int CW = COMP_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int SW = 2 * COMP_WIDTH;
    localparam int NS = CW + FB + 1;

    // Pipeline registers, stage s+1 is written from stage s
    logic                 r_v    [1:NS];
    logic                 r_zero [1:NS];
    logic [2:0]           r_neg  [1:NS];
    logic [2:0][CW-1:0]   r_mag  [1:NS];
    logic [SW-1:0]        r_rem  [1:NS];
    logic [CW-1:0]        r_root [1:NS];
    logic [2:0][CW:0]     r_dr   [1:NS];
    logic [2:0][FB:0]     r_q    [1:NS];

    logic                 r_ov;
    logic                 r_oz;
    logic [2:0][FB:0]     r_unit;
    logic                 w_adv;
    logic [2:0]           w_in_neg;
    logic [2:0][CW-1:0]   w_in_mag;
    logic [SW-1:0]        w_in_sum;

    assign w_adv = ~r_ov | ~i_stall;
    assign o_q_rd = ~i_q_stat.empty & w_adv;
    assign {w_in_neg, w_in_mag, w_in_sum} = i_q_data;

    for (genvar s = 0; s < NS; s++) begin : g_stg
        logic                v_i;
        logic                z_i;
        logic [2:0]          neg_i;
        logic [2:0][CW-1:0]  mag_i;
        logic [SW-1:0]       rem_i;
        logic [CW-1:0]       root_i;
        logic [2:0][CW:0]    dr_i;
        logic [2:0][FB:0]    q_i;
        logic [SW-1:0]       n_rem;
        logic [CW-1:0]       n_root;
        logic [2:0][CW:0]    n_dr;
        logic [2:0][FB:0]    n_q;

        // Stage source: queue head or previous stage
        if (s == 0) begin : g_src
            assign v_i    = o_q_rd;
            assign z_i    = (w_in_sum == '0);
            assign neg_i  = w_in_neg;
            assign mag_i  = w_in_mag;
            assign rem_i  = w_in_sum;
            assign root_i = '0;
            assign dr_i   = '0;
            assign q_i    = '0;
        end else begin : g_src
            assign v_i    = r_v[s];
            assign z_i    = r_zero[s];
            assign neg_i  = r_neg[s];
            assign mag_i  = r_mag[s];
            assign rem_i  = r_rem[s];
            assign root_i = r_root[s];
            assign dr_i   = r_dr[s];
            assign q_i    = r_q[s];
        end

        if (s < CW) begin : g_op
            // One root bit per stage: try root + 2^k against the remainder
            localparam int K = CW - 1 - s;
            logic [SW-1:0] trial;
            always_comb begin
                trial  = (SW'(root_i) << (K + 1)) + (SW'(1) << (2 * K));
                n_rem  = rem_i;
                n_root = root_i;
                if (rem_i >= trial) begin
                    n_rem     = rem_i - trial;
                    n_root[K] = 1'b1;
                end
                n_dr = dr_i;
                n_q  = q_i;
            end
        end else begin : g_op
            // One quotient bit per stage in each lane, restoring divide by the root
            localparam int J = FB - (s - CW);
            logic [2:0][CW:0] part;
            always_comb begin
                n_rem  = rem_i;
                n_root = root_i;
                n_q    = q_i;
                for (int l = 0; l < 3; l++) begin
                    if (s == CW) begin
                        part[l] = {1'b0, mag_i[l]};
                    end else begin
                        part[l] = {dr_i[l][CW-1:0], 1'b0};
                    end
                    n_dr[l] = part[l];
                    if (part[l] >= {1'b0, root_i}) begin
                        n_dr[l]   = part[l] - {1'b0, root_i};
                        n_q[l][J] = 1'b1;
                    end
                end
            end
        end

        // Valid bit of the next stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[s+1] <= v_i;
            end
        end

        // Payload of the next stage
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_zero[s+1] <= z_i;
                r_neg[s+1]  <= neg_i;
                r_mag[s+1]  <= mag_i;
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= n_root;
                r_dr[s+1]   <= n_dr;
                r_q[s+1]    <= n_q;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_v[NS];
        end
    end

    // Saturate to 2^FB-1, apply sign, force zeros for a zero vector
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oz <= r_zero[NS];
            for (int l = 0; l < 3; l++) begin
                if (r_zero[NS]) begin
                    r_unit[l] <= '0;
                end else if (r_q[NS][l][FB]) begin
                    r_unit[l] <= r_neg[NS][l] ? {1'b1, {(FB-1){1'b0}}, 1'b1}
                                              : {1'b0, {FB{1'b1}}};
                end else begin
                    r_unit[l] <= r_neg[NS][l] ? (~r_q[NS][l] + (FB+1)'(1)) : r_q[NS][l];
                end
            end
        end
    end

    assign o_valid       = r_ov;
    assign o_zero_length = r_oz;
    assign o_unit_x      = r_unit[0];
    assign o_unit_y      = r_unit[1];
    assign o_unit_z      = r_unit[2];

endmodule

// ===== hdl/vector3_normalize.sv =====
// Throughput: one vector per cycle unless a stall holds the flow; the square root and
// the divide are fully pipelined, one root bit and one quotient bit per stage.
// A queue of four entries between front and back lets each side stall on its own.
// Reset (i_rst_n low, synchronous) clears all valid flags and the queue; no data is kept.
`timescale 1ns / 1ps
module vector3_normalize import vn_pkg::*; #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_x,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_y,
    input  logic signed [COMP_WIDTH-1:0]  i_comp_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [FRAC_BITS:0]     o_unit_x,
    output logic signed [FRAC_BITS:0]     o_unit_y,
    output logic signed [FRAC_BITS:0]     o_unit_z,
    output logic                          o_zero_length
);
    localparam int DW = 3 + 5 * COMP_WIDTH;

    t_q_stat         w_q_stat;
    logic            w_q_wr;
    logic            w_q_rd;
    logic [DW-1:0]   w_q_wdata;
    logic [DW-1:0]   w_q_rdata;

    vn_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_comp_x (i_comp_x),
        .i_comp_y (i_comp_y),
        .i_comp_z (i_comp_z),
        .i_q_stat (w_q_stat),
        .o_q_wr   (w_q_wr),
        .o_q_data (w_q_wdata)
    );

    vn_queue #(.DATA_W(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_q_wdata),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    vn_back #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (w_q_stat),
        .i_q_data      (w_q_rdata),
        .o_q_rd        (w_q_rd),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_unit_z      (o_unit_z),
        .o_zero_length (o_zero_length)
    );

endmodule

// ===== hdl/vn_checker.sv =====
// Port-level checks for the vector normalizer, bound to the top level.
`timescale 1ns / 1ps
module vn_checker #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic signed [FRAC_BITS:0]     o_unit_x,
    input  logic signed [FRAC_BITS:0]     o_unit_y,
    input  logic signed [FRAC_BITS:0]     o_unit_z,
    input  logic                          o_zero_length
);
    localparam logic [FRAC_BITS:0] MOST_NEG = {1'b1, {FRAC_BITS{1'b0}}};

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_unit_x) && $stable(o_unit_y)
            && $stable(o_unit_z) && $stable(o_zero_length))
        else $error("stalled result changed");

    // Zero vector gives zeros
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero-length result not zero");

    // A nonzero vector always has a nonzero component
    a_nonzero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_length |-> o_unit_x != '0 || o_unit_y != '0 || o_unit_z != '0)
        else $error("nonzero vector gave all zeros");

    // Saturation keeps codes off the most negative value
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_unit_x != MOST_NEG && o_unit_y != MOST_NEG && o_unit_z != MOST_NEG)
        else $error("unsaturated most negative code");

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind vector3_normalize vn_checker #(
    .COMP_WIDTH(COMP_WIDTH),
    .FRAC_BITS (FRAC_BITS)
) u_vn_checker (.*);
